### hw/rtl/cml_pkg.sv
// Shared types and constants for the complex multilook amplitude detector.
// Used by the top level and by the square root unit; depends on nothing.
`timescale 1ns / 1ps

package cml_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned PROD_W   = 31;
  localparam int unsigned POWER_W  = 32;
  localparam int unsigned STORE_W  = 35;
  localparam int unsigned SUM_W    = 37;
  localparam int unsigned ROOT_W   = 19;
  localparam int unsigned AMP_W    = 18;

  localparam int unsigned CFG_W     = 14;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned AL_W      = 4;
  localparam int unsigned RL_W      = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AZIMUTH_LOOKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOOKS   = 2'd2;

  // Request into the square root unit.
  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] radicand;
    logic             last;
  } cml_sqrt_req_t;

  // Finished result of the square root unit, already saturated.
  typedef struct packed {
    logic             valid;
    logic [AMP_W-1:0] amplitude;
    logic             last;
  } cml_sqrt_rsp_t;

endpackage

### hw/rtl/cml_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies; contents are undefined until written.
`timescale 1ns / 1ps

module cml_ram #(
  parameter int unsigned WIDTH = 35,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/cml_isqrt.sv
// Iterative floor square root, one result bit per cycle, with saturation.
// Depends on cml_pkg for the request and result structs and widths.
`timescale 1ns / 1ps

module cml_isqrt (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cml_pkg::cml_sqrt_req_t req_i,
  output logic                   ready_o,
  output cml_pkg::cml_sqrt_rsp_t rsp_o,
  input  logic                   take_i
);
  import cml_pkg::*;

  localparam int unsigned RAD_W = 2 * ROOT_W;
  localparam int unsigned REM_W = ROOT_W + 1;
  localparam int unsigned CNT_W = $clog2(ROOT_W);

  typedef enum logic [1:0] {SQ_IDLE, SQ_RUN, SQ_DONE} sq_state_e;

  sq_state_e          state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [RAD_W-1:0]   rad_q, rad_d;
  logic [REM_W-1:0]   rem_q, rem_d;
  logic [ROOT_W-1:0]  root_q, root_d;
  logic               last_q, last_d;

  logic [REM_W+1:0]   rem_sh;
  logic [REM_W+1:0]   trial;
  logic [REM_W+1:0]   diff;

  // Restoring method: bring down two radicand bits, try to subtract 4*root+1.
  assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign diff   = rem_sh - trial;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rad_d   = rad_q;
    rem_d   = rem_q;
    root_d  = root_q;
    last_d  = last_q;
    case (state_q)
      SQ_IDLE: begin
        if (req_i.valid) begin
          rad_d   = RAD_W'(req_i.radicand);
          rem_d   = '0;
          root_d  = '0;
          last_d  = req_i.last;
          cnt_d   = CNT_W'(ROOT_W - 1);
          state_d = SQ_RUN;
        end
      end
      SQ_RUN: begin
        rad_d = {rad_q[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_d  = diff[REM_W-1:0];
          root_d = {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh[REM_W-1:0];
          root_d = {root_q[ROOT_W-2:0], 1'b0};
        end
        if (cnt_q == '0) begin
          state_d = SQ_DONE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      SQ_DONE: begin
        if (take_i) begin
          state_d = SQ_IDLE;
        end
      end
      default: state_d = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    last_q <= last_d;
  end

  assign ready_o         = (state_q == SQ_IDLE);
  assign rsp_o.valid     = (state_q == SQ_DONE);
  assign rsp_o.amplitude = root_q[ROOT_W-1] ? {AMP_W{1'b1}} : root_q[AMP_W-1:0];
  assign rsp_o.last      = last_q;

endmodule

### hw/rtl/complex_multilook_amplitude.sv
// Complex multilook amplitude detector. Each input item (I, Q) passes through
// the idle, load, accumulate and sum states in turn: accept with the column
// store read, the two squares, the store write, and the range sum update; no
// new item is taken until the last one is through. An item that closes a
// range group on the last line of an azimuth group also needs the square root
// unit free. The column store is one MAX_LINE_LENGTH x 35 RAM and has no
// clearing pass: the first line of each azimuth group overwrites it. The
// output register lets the next item enter while a finished pixel waits to be
// taken.
// Depends on cml_pkg, cml_ram and cml_isqrt.
`timescale 1ns / 1ps

module complex_multilook_amplitude #(
  parameter int unsigned MAX_LINE_LENGTH = 8192
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cml_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [cml_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [cml_pkg::SAMPLE_W-1:0] sample_i_i,
  input  logic signed [cml_pkg::SAMPLE_W-1:0] sample_q_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [cml_pkg::AMP_W-1:0]       amplitude_o,
  output logic                            last_in_line_o
);
  import cml_pkg::*;

  localparam int unsigned CW   = $clog2(MAX_LINE_LENGTH);
  localparam int unsigned CMPW = (CW + 1 > CFG_W + 1) ? CW + 1 : CFG_W + 1;

  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_ACC, S_SUM} state_e;

  state_e              state_q, state_d;
  logic [CFG_W-1:0]    line_length_q, line_length_d;
  logic [AL_W-1:0]     azimuth_looks_q, azimuth_looks_d;
  logic [RL_W-1:0]     range_looks_q, range_looks_d;
  logic [CW-1:0]       col_q, col_d;
  logic [2:0]          lli_q, lli_d;
  logic [SUM_W-1:0]    range_sum_q, range_sum_d;
  logic [1:0]          rc_q, rc_d;
  logic                out_valid_q, out_valid_d;

  logic signed [SAMPLE_W-1:0] si_q, sq_q;
  logic [PROD_W-1:0]   prod_i_q, prod_q_q;
  logic [STORE_W-1:0]  value_q, value_d;
  logic [AMP_W-1:0]    amp_q;
  logic                last_q;

  logic signed [2*SAMPLE_W-1:0] prod_i_s, prod_q_s;
  logic [POWER_W-1:0]  power;
  logic [STORE_W-1:0]  mem_rdata;
  logic                mem_we, mem_re;
  logic                accept;

  logic [CFG_W-1:0]    ll_eff;
  logic [AL_W-1:0]     al_eff;
  logic [RL_W-1:0]     rl_eff;
  logic [CMPW-1:0]     col_next_w;
  logic                last_col, first_line, last_line, close_group, sum_hold;
  logic [SUM_W-1:0]    sum_acc;

  cml_sqrt_req_t       sqrt_req;
  cml_sqrt_rsp_t       sqrt_rsp;
  logic                sqrt_ready, sqrt_take;

  // Out-of-range register values are clamped where they are used.
  assign ll_eff = (line_length_q == '0) ? CFG_W'(1) : line_length_q;
  assign al_eff = (azimuth_looks_q == '0) ? AL_W'(1) :
                  (azimuth_looks_q > AL_W'(8)) ? AL_W'(8) : azimuth_looks_q;
  assign rl_eff = (range_looks_q == '0) ? RL_W'(1) :
                  (range_looks_q > RL_W'(4)) ? RL_W'(4) : range_looks_q;

  assign col_next_w  = CMPW'({1'b0, col_q} + (CW + 1)'(1));
  assign last_col    = (col_next_w >= CMPW'(ll_eff)) ||
                       (col_next_w >= CMPW'(MAX_LINE_LENGTH));
  assign first_line  = (lli_q == '0);
  assign last_line   = (AL_W'({1'b0, lli_q}) + AL_W'(1)) >= al_eff;
  assign close_group = ((RL_W'({1'b0, rc_q}) + RL_W'(1)) >= rl_eff) || last_col;
  assign sum_acc     = range_sum_q + SUM_W'(value_q);

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  assign prod_i_s = si_q * si_q;
  assign prod_q_s = sq_q * sq_q;
  assign power    = POWER_W'(prod_i_q) + POWER_W'(prod_q_q);
  assign value_d  = first_line ? STORE_W'(power) : mem_rdata + STORE_W'(power);

  // Items are handled one at a time, so the store write of one item always
  // lands before the read of the next and no forwarding is needed.
  assign mem_re = accept;
  assign mem_we = (state_q == S_ACC);

  cml_ram #(
    .WIDTH (STORE_W),
    .DEPTH (MAX_LINE_LENGTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (col_q),
    .wdata_i (value_d),
    .re_i    (mem_re),
    .raddr_i (col_q),
    .rdata_o (mem_rdata)
  );

  // A closing item on the last azimuth line waits in the sum state until the root unit is free.
  assign sum_hold = (state_q == S_SUM) && last_line && close_group && !sqrt_ready;

  assign sqrt_req.valid    = (state_q == S_SUM) && last_line && close_group && sqrt_ready;
  assign sqrt_req.radicand = sum_acc;
  assign sqrt_req.last     = last_col;

  cml_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (sqrt_req),
    .ready_o (sqrt_ready),
    .rsp_o   (sqrt_rsp),
    .take_i  (sqrt_take)
  );

  assign sqrt_take = sqrt_rsp.valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d         = state_q;
    line_length_d   = line_length_q;
    azimuth_looks_d = azimuth_looks_q;
    range_looks_d   = range_looks_q;
    col_d           = col_q;
    lli_d           = lli_q;
    range_sum_d     = range_sum_q;
    rc_d            = rc_q;

    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LINE_LENGTH:   line_length_d   = cfg_wdata_i;
        CFG_AZIMUTH_LOOKS: azimuth_looks_d = cfg_wdata_i[AL_W-1:0];
        CFG_RANGE_LOOKS:   range_looks_d   = cfg_wdata_i[RL_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: state_d = S_ACC;
      S_ACC:  state_d = S_SUM;
      S_SUM: begin
        if (!sum_hold) begin
          state_d = S_IDLE;
          if (last_line) begin
            if (close_group) begin
              range_sum_d = '0;
              rc_d        = '0;
            end else begin
              range_sum_d = sum_acc;
              rc_d        = rc_q + 2'd1;
            end
          end
          if (last_col) begin
            col_d       = '0;
            range_sum_d = '0;
            rc_d        = '0;
            lli_d       = last_line ? 3'd0 : lli_q + 3'd1;
          end else begin
            col_d = col_q + CW'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (sqrt_take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      line_length_q   <= CFG_W'(6840);
      azimuth_looks_q <= AL_W'(4);
      range_looks_q   <= RL_W'(1);
      col_q           <= '0;
      lli_q           <= '0;
      range_sum_q     <= '0;
      rc_q            <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q         <= state_d;
      line_length_q   <= line_length_d;
      azimuth_looks_q <= azimuth_looks_d;
      range_looks_q   <= range_looks_d;
      col_q           <= col_d;
      lli_q           <= lli_d;
      range_sum_q     <= range_sum_d;
      rc_q            <= rc_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      si_q <= sample_i_i;
      sq_q <= sample_q_i;
    end
    if (state_q == S_LOAD) begin
      prod_i_q <= prod_i_s[PROD_W-1:0];
      prod_q_q <= prod_q_s[PROD_W-1:0];
    end
    if (state_q == S_ACC) begin
      value_q <= value_d;
    end
    if (sqrt_take) begin
      amp_q  <= sqrt_rsp.amplitude;
      last_q <= sqrt_rsp.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign amplitude_o    = amp_q;
  assign last_in_line_o = last_q;

`ifndef NO_ASSERTIONS
  a_sqrt_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_req.valid |-> sqrt_ready)
    else $error("square root started while busy");

  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_LOAD))
    else $error("accepted item did not start processing");

  a_ram_ports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !mem_re)
    else $error("store read and write overlap");

  a_line_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SUM) && !sum_hold && last_col) |=> (col_q == '0 && rc_q == '0))
    else $error("column counter did not wrap at end of line");
`endif

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the complex multilook amplitude detector.
// Feeds I/Q sample items through a queue-fed driver, predicts every pixel in
// a local model of the column store, and checks each pixel the monitor takes.
// Depends on cml_pkg and complex_multilook_amplitude.
`timescale 1ns / 1ps

module testbench;
  import cml_pkg::*;

  localparam int unsigned MAX_LEN      = 8192;
  localparam int unsigned AMP_MAX      = (1 << AMP_W) - 1;
  localparam int unsigned DRAIN_CYCLES = 48;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned CYCLE_LIMIT  = 3000000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
  } sample_t;

  typedef struct packed {
    logic [AMP_W-1:0] amp;
    logic             last;
  } pixel_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index_i = '0;
  logic [CFG_W-1:0]           cfg_wdata_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] sample_i_i = '0;
  logic signed [SAMPLE_W-1:0] sample_q_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [AMP_W-1:0]           amplitude_o;
  logic                       last_in_line_o;

  complex_multilook_amplitude #(
    .MAX_LINE_LENGTH(MAX_LEN)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_i_i    (sample_i_i),
    .sample_q_i    (sample_q_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .amplitude_o   (amplitude_o),
    .last_in_line_o(last_in_line_o)
  );

  sample_t     sample_queue[$];
  pixel_t      pixel_queue[$];
  int unsigned errors = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_start = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;

  // Local copy of the registers and of the detector state.
  logic [CFG_W-1:0]   line_length_q = 14'd6840;
  logic [AL_W-1:0]    az_looks_q = 4'd4;
  logic [RL_W-1:0]    rg_looks_q = 3'd1;
  logic [STORE_W-1:0] power_store[MAX_LEN];
  bit                 written[MAX_LEN];
  logic [12:0]        col_q = '0;
  logic [2:0]         look_q = '0;
  logic [SUM_W-1:0]   range_acc_q = '0;
  logic [1:0]         range_cnt_q = '0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_reg(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned root;
    longint unsigned probe;
    root = 0;
    probe = 64'h4000_0000_0000_0000;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v = v - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // Adds one sample to the column store and queues the pixel it completes.
  task automatic accumulate_sample(input sample_t s);
    longint unsigned    power;
    longint unsigned    root;
    logic [STORE_W-1:0] value;
    int unsigned        len;
    int unsigned        al;
    int unsigned        rl;
    bit                 last_col;
    bit                 last_line;
    pixel_t             px;
    len = clamp_reg(32'(line_length_q), MAX_LEN);
    al = clamp_reg(32'(az_looks_q), 8);
    rl = clamp_reg(32'(rg_looks_q), 4);
    power = longint'(s.re) * longint'(s.re) + longint'(s.im) * longint'(s.im);
    last_col = int'(col_q) + 1 >= len;
    last_line = int'(look_q) + 1 >= al;
    if (look_q == 0) value = power[STORE_W-1:0];
    else value = power_store[col_q] + power[STORE_W-1:0];
    power_store[col_q] = value;
    written[col_q] = 1'b1;
    if (last_line) begin
      range_acc_q = range_acc_q + value;
      if (int'(range_cnt_q) + 1 >= rl || last_col) begin
        root = floor_root(range_acc_q);
        if (root > AMP_MAX) root = AMP_MAX;
        px.amp = root[AMP_W-1:0];
        px.last = last_col;
        pixel_queue.push_back(px);
        range_acc_q = '0;
        range_cnt_q = '0;
      end else begin
        range_cnt_q = range_cnt_q + 1'b1;
      end
    end
    if (last_col) begin
      col_q = '0;
      range_acc_q = '0;
      range_cnt_q = '0;
      look_q = last_line ? 3'd0 : look_q + 3'd1;
    end else begin
      col_q = col_q + 1'b1;
    end
  endtask

  always @(posedge clk_i) begin : sample_driver
    bit took;
    took = in_valid_i && !in_stall_o;
    if (took) accumulate_sample(sample_queue.pop_front());
    if (!in_valid_i || took) begin
      if (rst_ni && sample_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        sample_i_i <= sample_queue[0].re;
        sample_q_i <= sample_queue[0].im;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : pixel_monitor
    pixel_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pixel_queue.size() == 0) begin
        $display("%t unexpected pixel: expected none, actual amplitude %0d last %0b",
                 $time, amplitude_o, last_in_line_o);
        errors++;
      end else begin
        want = pixel_queue.pop_front();
        if (want.amp !== amplitude_o) begin
          $display("%t amplitude mismatch: expected %0d, actual %0d",
                   $time, want.amp, amplitude_o);
          errors++;
        end
        if (want.last !== last_in_line_o) begin
          $display("%t last_in_line mismatch: expected %0b, actual %0b",
                   $time, want.last, last_in_line_o);
          errors++;
        end
      end
    end
  end

  // The receiver counts out a long hold-off on request, else stalls at random.
  always @(posedge clk_i) begin : stall_driver
    if (hold_start) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
    out_stall_i <= hold_start || hold_left != 0 || $urandom_range(0, 99) < recv_stall_pct;
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [SAMPLE_W-1:0] rand_part();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  task automatic offer(input int re, input int im);
    sample_t s;
    s.re = SAMPLE_W'(re);
    s.im = SAMPLE_W'(im);
    sample_queue.push_back(s);
  endtask

  task automatic offer_random(input int unsigned count);
    sample_t s;
    repeat (count) begin
      s.re = rand_part();
      s.im = rand_part();
      sample_queue.push_back(s);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value[CFG_W-1:0];
    case (idx)
      CFG_LINE_LENGTH:   line_length_q = value[CFG_W-1:0];
      CFG_AZIMUTH_LOOKS: az_looks_q = value[AL_W-1:0];
      CFG_RANGE_LOOKS:   rg_looks_q = value[RL_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(input int unsigned len, input int unsigned al, input int unsigned rl);
    write_reg(CFG_LINE_LENGTH, len);
    write_reg(CFG_AZIMUTH_LOOKS, al);
    write_reg(CFG_RANGE_LOOKS, rl);
    @(negedge clk_i);
  endtask

  // Waits until every item is taken and every pixel has come, then lets the
  // pipeline run dry for items that complete no pixel.
  task automatic wait_drained();
    @(negedge clk_i);
    while (sample_queue.size() != 0 || in_valid_i || pixel_queue.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // A longer line mid-group would read columns never written since reset.
  function automatic bit len_safe(input int unsigned len);
    if (look_q == 0) return 1'b1;
    for (int unsigned c = 0; c < len; c++)
      if (!written[c]) return 1'b0;
    return 1'b1;
  endfunction

  initial begin : stimulus
    int unsigned al_raw;
    int unsigned rl_raw;
    int unsigned len_raw;
    int unsigned len_hi;
    int unsigned line_items;
    int unsigned count;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Zero registers act as one: every item is its own pixel.
    configure(0, 0, 0);
    offer(-32768, -32768);
    offer(32767, 32767);
    offer(-32768, 32767);
    offer(32767, -32768);
    offer(0, 0);
    offer(1, -1);
    offer(-1, 0);
    wait_drained();

    // A line of five with range looks of two closes its last group early.
    configure(5, 1, 2);
    offer_random(5);
    wait_drained();

    // Full-scale window over eight lines and four columns saturates.
    configure(4, 8, 4);
    repeat (32) offer(-32768, -32768);
    wait_drained();

    // Azimuth looks above eight act as eight.
    configure(2, 15, 1);
    offer_random(16);
    wait_drained();

    // Line length beyond the store size and range looks above four.
    configure(16383, 0, 7);
    offer_random(128);
    wait_drained();

    // Fill the block and its output while the receiver holds off.
    configure(8, 1, 1);
    offer_random(120);
    hold_start = 1'b1;
    @(negedge clk_i);
    hold_start = 1'b0;
    wait_drained();

    for (int p = 0; p < 12; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      al_raw = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
      rl_raw = $urandom_range(0, 7);
      len_hi = 320 / clamp_reg(al_raw, 8);
      case ($urandom_range(0, 15))
        0:       len_raw = 0;
        1:       len_raw = $urandom_range(25, len_hi);
        default: len_raw = $urandom_range(1, 24);
      endcase
      if (!len_safe(clamp_reg(len_raw, MAX_LEN))) len_raw = 32'(line_length_q);
      configure(len_raw, al_raw, rl_raw);
      line_items = clamp_reg(len_raw, MAX_LEN) * clamp_reg(al_raw, 8);
      count = (100 / line_items == 0) ? line_items : (100 / line_items) * line_items;
      // Half the phases stop mid-group so the next settings apply mid-stream.
      if ($urandom_range(0, 1) == 1) count += $urandom_range(0, line_items - 1);
      offer_random(count);
      wait_drained();
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/cml_pkg.sv
hw/rtl/cml_ram.sv
hw/rtl/cml_isqrt.sv
hw/rtl/complex_multilook_amplitude.sv
tb/sv/testbench.sv
